FILE: hw/rtl/gdbl_pkg.sv
// Shared types, constants and row functions for the glyph row doubler.
package gdbl_pkg;

  localparam int RowW    = 8;
  localparam int OutW    = 16;
  localparam int QDepth  = 4;
  localparam int QAw     = $clog2(QDepth);

  localparam logic [OutW-1:0] PairTopMask  = 16'hc000;
  localparam logic [RowW-1:0] PixelTopMask = 8'h80;

  // One queue entry: every row that one input beat causes, already computed.
  typedef struct packed {
    logic            has_prev;
    logic [OutW-1:0] prev_bottom;
    logic [OutW-1:0] top;
    logic            last;
    logic [OutW-1:0] last_bottom;
  } gdbl_entry_t;

  function automatic logic [OutW-1:0] widen_row(input logic [RowW-1:0] bits);
    logic [OutW-1:0] res;
    res = '0;
    for (int k = 0; k < RowW; k++) begin
      if ((bits & (PixelTopMask >> k)) != '0) res = res | (PairTopMask >> (2 * k));
    end
    return res;
  endfunction

  // Fill an empty pair when exactly one diagonal test against nb passes.
  function automatic logic [OutW-1:0] diag_fill(input logic [OutW-1:0] own,
                                                input logic [OutW-1:0] nb);
    logic [OutW-1:0] res;
    logic [OutW-1:0] pm;
    logic            rt;
    logic            lt;
    res = own;
    for (int k = 0; k < RowW; k++) begin
      pm = PairTopMask >> (2 * k);
      rt = 1'b0;
      lt = 1'b0;
      if ((own & pm) == '0) begin
        if (k < RowW - 2)
          rt = ((nb & pm) == pm) && ((nb & (pm >> 2)) != '0) && ((own & (pm >> 2)) != '0);
        if (k > 0)
          lt = ((nb & pm) == pm) && ((nb & (pm << 2)) != '0) && ((own & (pm << 2)) != '0);
        if (lt && !rt) res = res | (pm << 1);
        if (rt && !lt) res = res | (pm >> 1);
      end
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/gdbl_front.sv
// Front end: accepts source rows, tracks glyph state and computes the rows each beat owes.
module gdbl_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [gdbl_pkg::RowW-1:0]   s_axis_tdata,   // row_bits
  input  logic                        s_axis_tlast,   // last_row
  input  logic                        q_full,
  output logic                        q_push,
  output gdbl_pkg::gdbl_entry_t       q_data
);
  import gdbl_pkg::*;

  logic            smoothing_on;
  logic [OutW-1:0] prior_top;
  logic [RowW-1:0] held_row;
  logic            row_pending;

  logic [OutW-1:0] cur;
  logic [OutW-1:0] held_w;
  logic [OutW-1:0] top;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cur    = widen_row(s_axis_tdata);
    held_w = widen_row(held_row);
    top    = smoothing_on ? diag_fill(cur, prior_top) : cur;
    q_data.has_prev    = row_pending;
    q_data.prev_bottom = smoothing_on ? diag_fill(held_w, cur) : held_w;
    q_data.top         = top;
    q_data.last        = s_axis_tlast;
    q_data.last_bottom = smoothing_on ? diag_fill(cur, '0) : cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_on <= 1'b0;
      prior_top    <= '0;
      held_row     <= '0;
      row_pending  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) smoothing_on <= cfg_data;
      if (q_push) begin
        if (s_axis_tlast) begin
          // glyph closed: nothing owed, next glyph starts with a blank row above
          prior_top   <= '0;
          held_row    <= '0;
          row_pending <= 1'b0;
        end else begin
          prior_top   <= top;
          held_row    <= s_axis_tdata;
          row_pending <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/gdbl_fifo.sv
// Short queue of computed row groups between the front and back ends.
module gdbl_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  gdbl_pkg::gdbl_entry_t din,
  output logic                  full,
  input  logic                  pop,
  output gdbl_pkg::gdbl_entry_t dout,
  output logic                  not_empty
);
  import gdbl_pkg::*;

  gdbl_entry_t   mem [QDepth];
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic [QAw:0]   count;

  assign full      = (count == (QAw+1)'(QDepth));
  assign not_empty = (count != '0);
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/gdbl_back.sv
// Back end: walks each queued row group and sends its rows one beat at a time.
module gdbl_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  gdbl_pkg::gdbl_entry_t       q_data,
  output logic                        q_pop,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [gdbl_pkg::OutW-1:0]   m_axis_tdata,   // out_row
  output logic                        m_axis_tlast    // glyph_end
);
  import gdbl_pkg::*;

  typedef enum logic [1:0] {PH_PREV, PH_TOP, PH_LAST} phase_t;

  phase_t          phase;
  phase_t          phase_next;
  gdbl_entry_t     ent;
  logic            ent_valid;
  logic            load;
  logic            emit;
  logic            finish;
  logic [OutW-1:0] row_sel;

  always_comb begin
    load = !m_axis_tvalid || m_axis_tready;
    emit = ent_valid && load;
    unique case (phase)
      PH_PREV: begin
        row_sel    = ent.prev_bottom;
        phase_next = PH_TOP;
        finish     = 1'b0;
      end
      PH_TOP: begin
        row_sel    = ent.top;
        phase_next = PH_LAST;
        finish     = !ent.last;
      end
      PH_LAST: begin
        row_sel    = ent.last_bottom;
        phase_next = PH_TOP;
        finish     = 1'b1;
      end
      default: begin
        row_sel    = ent.top;
        phase_next = PH_TOP;
        finish     = 1'b1;
      end
    endcase
    // refill the group register as the last row of the current one goes out
    q_pop = q_valid && (!ent_valid || (emit && finish));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid     <= 1'b0;
      phase         <= PH_TOP;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load) m_axis_tvalid <= ent_valid;
      if (emit) begin
        m_axis_tdata <= row_sel;
        m_axis_tlast <= (phase == PH_LAST);
      end
      if (q_pop) begin
        ent       <= q_data;
        ent_valid <= 1'b1;
        phase     <= q_data.has_prev ? PH_PREV : PH_TOP;
      end else if (emit && finish) begin
        ent_valid <= 1'b0;
      end else if (emit) begin
        phase <= phase_next;
      end
    end
  end

endmodule

FILE: hw/rtl/glyph_row_doubler_smoother.sv
// Top level of the 2x glyph row doubler with optional diagonal smoothing.
// Feed glyph rows on the s_axis channel: tdata[7:0] is the row, bit 7 the
// leftmost pixel, and tlast marks the final row of a glyph. Doubled 16-bit
// rows leave on m_axis, bit 15 leftmost; tlast flags the last row of a glyph.
// Each source row yields its top row at once and its bottom row with the next
// source row, or right after the top row when tlast is set.
// The cfg channel writes the one smoothing enable bit (cfg_data); cfg_ready is
// always high, and writes belong between glyphs while the block is drained.
// With the back end idle, a beat's first row reaches m_axis through the
// queue and the group and output registers; a top row behind an owed bottom
// row follows it.
// Throughput: one output row per cycle while m_axis is ready, set by the
// single output port. A middle source row yields two rows, the first of a
// glyph one and the last of a longer glyph three. A four-entry queue between
// front and back keeps s_axis accepting while m_axis stalls, until it fills.
// Reset (rst, synchronous) clears the queue, the glyph state and smoothing.
module glyph_row_doubler_smoother (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data,       // smoothing_on
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [gdbl_pkg::RowW-1:0]   s_axis_tdata,   // row_bits
  input  logic                        s_axis_tlast,   // last_row
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [gdbl_pkg::OutW-1:0]   m_axis_tdata,   // out_row
  output logic                        m_axis_tlast    // glyph_end
);
  import gdbl_pkg::*;

  gdbl_entry_t push_data;
  gdbl_entry_t head_data;
  logic        push;
  logic        full;
  logic        pop;
  logic        not_empty;

  gdbl_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (full),
    .q_push        (push),
    .q_data        (push_data)
  );

  gdbl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (push_data),
    .full      (full),
    .pop       (pop),
    .dout      (head_data),
    .not_empty (not_empty)
  );

  gdbl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (not_empty),
    .q_data        (head_data),
    .q_pop         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
